>>> rtl/pgrs_pkg.sv
// Package: types, constants and tables for the position-gated random stimulus block.
package pgrs_pkg;

    localparam int MAX_CIRCLES = 16;
    localparam int SLOT_W      = 4;

    localparam logic [2:0] REG_STIM_ENABLE    = 3'd0;
    localparam logic [2:0] REG_RATE           = 3'd1;
    localparam logic [2:0] REG_GAUSSIAN_MODE  = 3'd2;
    localparam logic [2:0] REG_FALLOFF_COEF   = 3'd3;
    localparam logic [2:0] REG_OUTPUT_CHANNEL = 3'd4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  circle_slot;
        logic        slot_valid;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] radius;
        logic [19:0] elapsed_us;
        logic [15:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic       pulse;
        logic [7:0] ttl_mask;
        logic       inside_res;
        logic [3:0] hit_slot;
        logic       rate_exceeded;
    } t_out_item;

    typedef struct packed {
        logic       stim_enable;
        logic [23:0] rate;
        logic       gaussian_mode;
        logic [15:0] falloff_coef;
        logic [2:0] output_channel;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SCAN, ST_DIV, ST_EXPA, ST_SERIES, ST_GAIN,
        ST_REFF, ST_PMUL, ST_PDIV, ST_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic load;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic expa;
        logic ser_init;
        logic ser_step;
        logic gain;
        logic reff;
        logic pmul;
        logic pdiv_init;
        logic pdiv_step;
        logic emit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_sample;
        logic scan_done;
        logic found;
        logic stim;
        logic gauss;
        logic div_done;
        logic ser_done;
        logic pdiv_done;
    } t_sts;

    function automatic logic [16:0] exp_int(input logic [3:0] i);
        case (i)
            4'd0:    exp_int = 17'd65536;
            4'd1:    exp_int = 17'd24109;
            4'd2:    exp_int = 17'd8869;
            4'd3:    exp_int = 17'd3263;
            4'd4:    exp_int = 17'd1200;
            4'd5:    exp_int = 17'd442;
            4'd6:    exp_int = 17'd162;
            4'd7:    exp_int = 17'd60;
            4'd8:    exp_int = 17'd22;
            4'd9:    exp_int = 17'd8;
            4'd10:   exp_int = 17'd3;
            4'd11:   exp_int = 17'd1;
            default: exp_int = 17'd0;
        endcase
    endfunction

    // Reciprocal of k = 1..10 in Q1.31, rounded up. The floor is exact while
    // t * (k*R - 2^31) < 2^31, which every series term satisfies.
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        case (k)
            4'd1:    recip_k = 32'd2147483648;
            4'd2:    recip_k = 32'd1073741824;
            4'd3:    recip_k = 32'd715827883;
            4'd4:    recip_k = 32'd536870912;
            4'd5:    recip_k = 32'd429496730;
            4'd6:    recip_k = 32'd357913942;
            4'd7:    recip_k = 32'd306783379;
            4'd8:    recip_k = 32'd268435456;
            4'd9:    recip_k = 32'd238609295;
            default: recip_k = 32'd214748365;
        endcase
    endfunction

endpackage

>>> rtl/pgrs_ctrl.sv
// Controller: sequences one item, either a table load or a scan with gaussian gain and probability steps.
module pgrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pgrs_pkg::t_sts i_sts,
    output pgrs_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import pgrs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_LOAD;
            ST_LOAD: begin
                if (i_sts.is_sample) n_state = ST_SCAN;
                else n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    if (!i_sts.found || !i_sts.stim) n_state = ST_DONE;
                    else if (i_sts.gauss) n_state = ST_DIV;
                    else n_state = ST_PMUL;
                end
            end
            ST_DIV:    if (i_sts.div_done) n_state = ST_EXPA;
            ST_EXPA:   n_state = ST_SERIES;
            ST_SERIES: if (i_sts.ser_done) n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_REFF;
            ST_REFF:   n_state = ST_PMUL;
            ST_PMUL:   n_state = ST_PDIV;
            ST_PDIV:   if (i_sts.pdiv_done) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:   o_cmd.capture = i_start;
            ST_LOAD: begin
                o_cmd.load      = ~i_sts.is_sample;
                o_cmd.scan_init = i_sts.is_sample;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.div_init  = 1'b1;
            end
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_EXPA: begin
                o_cmd.expa     = 1'b1;
                o_cmd.ser_init = 1'b1;
            end
            ST_SERIES: o_cmd.ser_step = 1'b1;
            ST_GAIN:   o_cmd.gain = 1'b1;
            ST_REFF:   o_cmd.reff = 1'b1;
            ST_PMUL: begin
                o_cmd.pmul      = 1'b1;
                o_cmd.pdiv_init = 1'b1;
            end
            ST_PDIV:   o_cmd.pdiv_step = 1'b1;
            ST_DONE:   o_cmd.emit = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> rtl/pgrs_dp.sv
// Datapath: circle table, scan, normalizing divider, exp series and probability.
module pgrs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pgrs_pkg::t_in_item  i_item,
    input  pgrs_pkg::t_cfg      i_cfg,
    input  pgrs_pkg::t_cmd      i_cmd,
    output pgrs_pkg::t_sts      o_sts,
    output pgrs_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    import pgrs_pkg::*;

    // Circle table: valid bits reset, payload written on load.
    logic [MAX_CIRCLES-1:0] r_valid;
    logic [15:0] r_cx  [MAX_CIRCLES];
    logic [15:0] r_cy  [MAX_CIRCLES];
    logic [15:0] r_rad [MAX_CIRCLES];

    t_in_item    r_item;
    logic [SLOT_W:0] r_idx;
    logic        r_found;
    logic [3:0]  r_hit;
    logic [32:0] r_d2;
    logic [31:0] r_r2;
    // Long divider for n = d2*65536/r2 (at most 65536).
    logic [32:0] r_rem;
    logic [16:0] r_quo;
    logic [4:0]  r_dcnt;
    logic [15:0] r_a;
    // Series
    logic [30:0] r_t;
    logic [31:0] r_even, r_odd;
    logic [3:0]  r_k;
    logic        r_sph;      // 0: multiply by x, 1: divide by k
    logic [16:0] r_g;
    logic [23:0] r_reff;
    logic [45:0] r_pnum;     // elapsed*reff*4, with reff = rate in uniform mode
    logic        r_pexc;
    logic        r_pfire;
    logic        r_pdone;
    t_out_item   r_res;
    logic        r_res_v;

    localparam logic [13:0] DIVISOR_P = 14'd15625;
    // 65537 * 15625: smallest numerator whose probability exceeds one.
    localparam logic [45:0] P_SAT_NUM = 46'd1024015625;

    // Scan one slot per cycle.
    logic [3:0]  w_sidx;
    logic [15:0] w_dx, w_dy;
    logic [31:0] w_dx2, w_dy2;
    logic [32:0] w_s;
    logic [31:0] w_rr;
    assign w_sidx = r_idx[SLOT_W-1:0];
    assign w_dx = (r_item.pos_x >= r_cx[w_sidx]) ? r_item.pos_x - r_cx[w_sidx]
                                                 : r_cx[w_sidx] - r_item.pos_x;
    assign w_dy = (r_item.pos_y >= r_cy[w_sidx]) ? r_item.pos_y - r_cy[w_sidx]
                                                 : r_cy[w_sidx] - r_item.pos_y;
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_s   = {1'b0, w_dx2} + {1'b0, w_dy2};
    assign w_rr  = r_rad[w_sidx] * r_rad[w_sidx];

    logic w_hit_now;
    assign w_hit_now = !r_found && !r_idx[SLOT_W] && r_valid[w_sidx] &&
                       (w_s <= {1'b0, w_rr});

    // Divider step
    logic [33:0] w_rem_sh;
    assign w_rem_sh = {r_rem, 1'b0};

    // Series step
    logic [61:0] w_tx;
    logic [62:0] w_tdiv;
    assign w_tx   = r_t * {1'b0, r_a[11:0], 18'd0};
    assign w_tdiv = r_t * recip_k(r_k);

    logic [32:0] w_frac;
    assign w_frac = (r_even >= r_odd) ? {1'b0, r_even - r_odd} : 33'd0;

    logic [49:0] w_gprod;
    logic [40:0] w_rprod;
    logic [43:0] w_pprod;
    assign w_gprod = exp_int(r_a[15:12]) * w_frac;
    assign w_rprod = i_cfg.rate * r_g;
    assign w_pprod = r_item.elapsed_us * (i_cfg.gaussian_mode ? r_reff : i_cfg.rate);

    // Pulse when random < floor(num/15625), i.e. num >= (random+1)*15625.
    logic [16:0] w_rnd1;
    logic [30:0] w_pthr;
    assign w_rnd1 = {1'b0, r_item.random_value} + 17'd1;
    assign w_pthr = w_rnd1 * DIVISOR_P;

    logic [31:0] w_adiv;
    assign w_adiv = i_cfg.falloff_coef * r_quo;

    t_out_item w_res;
    always_comb begin
        w_res = '0;
        if (r_item.operation == OP_SAMPLE && r_found) begin
            w_res.inside_res = 1'b1;
            w_res.hit_slot   = r_hit;
            if (i_cfg.stim_enable) begin
                w_res.rate_exceeded = r_pexc;
                if (r_pfire) begin
                    w_res.pulse    = 1'b1;
                    w_res.ttl_mask = 8'd1 << i_cfg.output_channel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= i_cmd.emit;
            if (i_cmd.load) begin
                r_valid[r_item.circle_slot] <= r_item.slot_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load) begin
            r_cx[r_item.circle_slot]  <= r_item.slot_valid ? r_item.pos_x  : 16'd0;
            r_cy[r_item.circle_slot]  <= r_item.slot_valid ? r_item.pos_y  : 16'd0;
            r_rad[r_item.circle_slot] <= r_item.slot_valid ? r_item.radius : 16'd0;
        end
        if (i_cmd.scan_init) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_hit   <= '0;
        end
        if (i_cmd.scan_step && !r_idx[SLOT_W] && !r_found) begin
            r_idx <= r_idx + 1'b1;
            if (w_hit_now) begin
                r_found <= 1'b1;
                r_hit   <= w_sidx;
                r_d2    <= w_s;
                r_r2    <= w_rr;
            end
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step && r_dcnt != 5'd17) begin
            // Dividend is d2 << 16 with d2 <= r2: the first step settles the
            // integer bit, then 16 shift steps give the fraction bits.
            if (r_dcnt == 5'd0) begin
                if (r_r2 == 32'd0) begin
                    r_rem <= '0;
                    r_quo <= '0;
                end else if (r_d2 >= {1'b0, r_r2}) begin
                    r_rem <= r_d2 - {1'b0, r_r2};
                    r_quo <= 17'd1;
                end else begin
                    r_rem <= r_d2;
                    r_quo <= '0;
                end
                r_dcnt <= 5'd1;
            end else begin
                if (r_r2 == 32'd0) begin
                    r_quo <= '0;
                end else if (w_rem_sh >= {2'b0, r_r2}) begin
                    r_rem <= 33'(w_rem_sh - {2'b0, r_r2});
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[32:0];
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
        if (i_cmd.expa) begin
            r_a <= w_adiv[31:16];
        end
        if (i_cmd.ser_init) begin
            r_t    <= 31'h4000_0000;
            r_even <= 32'h4000_0000;
            r_odd  <= '0;
            r_k    <= 4'd1;
            r_sph  <= 1'b0;
        end
        if (i_cmd.ser_step && r_k <= 4'd10) begin
            if (!r_sph) begin
                r_t   <= w_tx[60:30];
                r_sph <= 1'b1;
            end else begin
                r_t   <= w_tdiv[61:31];
                r_sph <= 1'b0;
                r_k   <= r_k + 1'b1;
                if (r_k[0]) r_odd <= r_odd + {1'b0, w_tdiv[61:31]};
                else r_even <= r_even + {1'b0, w_tdiv[61:31]};
            end
        end
        if (i_cmd.gain) begin
            r_g <= w_gprod[46:30];
        end
        if (i_cmd.reff) begin
            r_reff <= w_rprod[39:16];
        end
        if (i_cmd.pmul) begin
            r_pnum <= {w_pprod, 2'b0};
        end
        if (i_cmd.pdiv_init) begin
            r_pdone <= 1'b0;
        end
        if (i_cmd.pdiv_step) begin
            r_pexc  <= (r_pnum >= P_SAT_NUM);
            r_pfire <= (r_pnum >= {15'd0, w_pthr});
            r_pdone <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_res <= w_res;
        end
    end

    assign o_sts.is_sample = (r_item.operation == OP_SAMPLE);
    assign o_sts.scan_done = r_found || r_idx[SLOT_W];
    assign o_sts.found     = r_found;
    assign o_sts.stim      = i_cfg.stim_enable;
    assign o_sts.gauss     = i_cfg.gaussian_mode;
    assign o_sts.div_done  = (r_dcnt == 5'd17);
    assign o_sts.ser_done  = (r_k == 4'd11);
    assign o_sts.pdiv_done = r_pdone;
    assign o_result        = r_res;
    assign o_result_valid  = r_res_v;

endmodule

>>> rtl/position_gated_random_stimulus.sv
// Top level: APB register bank, controller and datapath of the stimulus block.
//
// Raise start with an item while busy is low; the item is taken at that edge.
// A load item passes the load and done states before its result is shown. A
// position sample scans one circle slot per cycle until a hit or the last
// slot; on a miss, or a hit with stimulation off, it goes straight to done,
// in uniform mode through the probability multiply and compare, and gaussian
// mode adds a normalizing divider, an exp series and the gain steps before
// these. The probability test compares against (random+1)*15625
// and needs no divide. busy drops in the cycle the result is shown, so the
// next transaction can be taken at the edge that ends it. The result is on
// o_result for exactly one cycle with o_result_valid high; the receiver cannot
// stall it, so capture it then. Write configuration only while busy is low.
module position_gated_random_stimulus (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pgrs_pkg::t_in_item            i_item,
    output pgrs_pkg::t_out_item           o_result,
    output logic                          o_result_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pgrs_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_STIM_ENABLE:    r_cfg.stim_enable    <= pwdata[0];
                REG_RATE:           r_cfg.rate           <= pwdata[23:0];
                REG_GAUSSIAN_MODE:  r_cfg.gaussian_mode  <= pwdata[0];
                REG_FALLOFF_COEF:   r_cfg.falloff_coef   <= pwdata[15:0];
                REG_OUTPUT_CHANNEL: r_cfg.output_channel <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STIM_ENABLE:    prdata = {31'd0, r_cfg.stim_enable};
            REG_RATE:           prdata = {8'd0, r_cfg.rate};
            REG_GAUSSIAN_MODE:  prdata = {31'd0, r_cfg.gaussian_mode};
            REG_FALLOFF_COEF:   prdata = {16'd0, r_cfg.falloff_coef};
            REG_OUTPUT_CHANNEL: prdata = {29'd0, r_cfg.output_channel};
            default:            prdata = '0;
        endcase
    end

    pgrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pgrs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg          (r_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

>>> bench/tb_position_gated_random_stimulus.sv
// Testbench for the position-gated random stimulus block: random and directed transactions.
`timescale 1ns / 1ps

module tb_position_gated_random_stimulus;
    import pgrs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    t_out_item   o_result;
    logic        o_result_valid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    position_gated_random_stimulus uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result(o_result), .o_result_valid(o_result_valid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int CYCLE_LIMIT = 2000000;

    // Shadow copy of the circle table and registers, used for prediction.
    logic        shd_valid [MAX_CIRCLES];
    logic [15:0] shd_cx    [MAX_CIRCLES];
    logic [15:0] shd_cy    [MAX_CIRCLES];
    logic [15:0] shd_rad   [MAX_CIRCLES];
    t_cfg        shd_cfg;

    t_in_item    pending_items[$];
    t_out_item   expected_results[$];
    int          mismatch_count;
    int          cycle_count;

    // Driver state: gap cycles before the next transaction.
    int          gap_left;
    bit          drv_active;

    // exp(-F/4096) in Q1.30 by an alternating series up to the tenth power.
    function automatic logic [63:0] exp_frac(input logic [11:0] f);
        logic [63:0] x, t, ev, od;
        int k;
        x  = 64'(f) << 18;
        t  = 64'd1 << 30;
        ev = t;
        od = 0;
        for (k = 1; k <= 10; k++) begin
            t = ((t * x) >> 30) / k;
            if (k % 2) od += t; else ev += t;
        end
        return (ev >= od) ? ev - od : 64'd0;
    endfunction

    function automatic logic [63:0] exp_whole(input logic [3:0] i);
        logic [63:0] tab [16];
        tab = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1, 0, 0, 0, 0};
        return tab[i];
    endfunction

    // Apply one transaction to the shadow table and return the predicted result.
    function automatic t_out_item predict_stimulus(input t_in_item it);
        t_out_item   r;
        logic [63:0] d2, r2, s, rr, dx, dy, reff, n, a, g, p;
        bit          found;
        int          i;
        r = '0;
        found = 0;
        d2 = 0;
        r2 = 0;
        if (it.operation == OP_LOAD) begin
            shd_valid[it.circle_slot] = it.slot_valid;
            shd_cx[it.circle_slot]    = it.slot_valid ? it.pos_x : 16'd0;
            shd_cy[it.circle_slot]    = it.slot_valid ? it.pos_y : 16'd0;
            shd_rad[it.circle_slot]   = it.slot_valid ? it.radius : 16'd0;
            return r;
        end
        for (i = 0; i < MAX_CIRCLES; i++) begin
            if (!found && shd_valid[i]) begin
                dx = (it.pos_x >= shd_cx[i]) ? 64'(it.pos_x - shd_cx[i])
                                             : 64'(shd_cx[i] - it.pos_x);
                dy = (it.pos_y >= shd_cy[i]) ? 64'(it.pos_y - shd_cy[i])
                                             : 64'(shd_cy[i] - it.pos_y);
                s  = dx * dx + dy * dy;
                rr = 64'(shd_rad[i]) * 64'(shd_rad[i]);
                if (s <= rr) begin
                    found = 1;
                    r.hit_slot = i[3:0];
                    d2 = s;
                    r2 = rr;
                end
            end
        end
        if (!found) return r;
        r.inside_res = 1'b1;
        if (!shd_cfg.stim_enable) return r;
        reff = 64'(shd_cfg.rate);
        if (shd_cfg.gaussian_mode) begin
            n = (r2 != 0) ? (d2 << 16) / r2 : 64'd0;
            a = (64'(shd_cfg.falloff_coef) * n) >> 16;
            if (a > 64'hFFFF) a = 64'hFFFF;
            g = (exp_whole(a[15:12]) * exp_frac(a[11:0])) >> 30;
            reff = (reff * g) >> 16;
        end
        p = (64'(it.elapsed_us) * reff * 4) / 15625;
        if (p > 65536) begin
            r.rate_exceeded = 1'b1;
            p = 65536;
        end
        if (64'(it.random_value) < p) begin
            r.pulse = 1'b1;
            r.ttl_mask = 8'd1 << shd_cfg.output_channel;
        end
        return r;
    endfunction

    // Append one transaction to the driver's queue.
    function automatic void queue_item(input t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Clock: 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Driver: pop the next item, hold start until the block takes it, then idle a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            drv_active <= 1'b0;
            gap_left   <= 0;
        end else if (drv_active) begin
            // Transaction taken at this edge when start is high and busy low.
            if (start && !busy) begin
                expected_results.insert(expected_results.size(), predict_stimulus(i_item));
                if (gap_left == 0 && pending_items.size() > 0) begin
                    i_item   <= pending_items.pop_front();
                    gap_left <= int'($urandom_range(0, 3));
                end else begin
                    start      <= 1'b0;
                    drv_active <= 1'b0;
                end
            end
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
            i_item     <= pending_items.pop_front();
            start      <= 1'b1;
            drv_active <= 1'b1;
            gap_left   <= int'($urandom_range(0, 3));
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.pulse != want.pulse)
                    report_mismatch("pulse", o_result.pulse, want.pulse);
                if (o_result.ttl_mask != want.ttl_mask)
                    report_mismatch("ttl_mask", o_result.ttl_mask, want.ttl_mask);
                if (o_result.inside_res != want.inside_res)
                    report_mismatch("inside_res", o_result.inside_res, want.inside_res);
                if (o_result.hit_slot != want.hit_slot)
                    report_mismatch("hit_slot", o_result.hit_slot, want.hit_slot);
                if (o_result.rate_exceeded != want.rate_exceeded)
                    report_mismatch("rate_exceeded", o_result.rate_exceeded,
                                    want.rate_exceeded);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("position_gated_random_stimulus: mismatch");
            $finish;
        end
    end

    // Wait until every queued item is taken and every result has arrived.
    task automatic drain();
        while (pending_items.size() > 0 || drv_active || gap_left > 0 ||
               expected_results.size() > 0)
            @(posedge i_clk);
        // Let the block settle back to idle before touching the registers.
        repeat (8) @(posedge i_clk);
    endtask

    // Write one register through the APB port: setup then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STIM_ENABLE:    shd_cfg.stim_enable    = value[0];
            REG_RATE:           shd_cfg.rate           = value[23:0];
            REG_GAUSSIAN_MODE:  shd_cfg.gaussian_mode  = value[0];
            REG_FALLOFF_COEF:   shd_cfg.falloff_coef   = value[15:0];
            REG_OUTPUT_CHANNEL: shd_cfg.output_channel = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [23:0] rt, input logic gm,
                              input logic [15:0] coef, input logic [2:0] ch);
        write_reg(REG_STIM_ENABLE, 32'(en));
        write_reg(REG_RATE, 32'(rt));
        write_reg(REG_GAUSSIAN_MODE, 32'(gm));
        write_reg(REG_FALLOFF_COEF, 32'(coef));
        write_reg(REG_OUTPUT_CHANNEL, 32'(ch));
    endtask

    function automatic t_in_item load_item(input logic [3:0] slot, input logic v,
                                           input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] r);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, 26'($urandom)});
        it.operation   = OP_LOAD;
        it.circle_slot = slot;
        it.slot_valid  = v;
        it.pos_x       = x;
        it.pos_y       = y;
        it.radius      = r;
        return it;
    endfunction

    function automatic t_in_item sample_item(input logic [15:0] x, input logic [15:0] y,
                                             input logic [19:0] el, input logic [15:0] rnd);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, 26'($urandom)});
        it.operation    = OP_SAMPLE;
        it.pos_x        = x;
        it.pos_y        = y;
        it.elapsed_us   = el;
        it.random_value = rnd;
        return it;
    endfunction

    // Random sample: mostly near a stored circle so the probability path is exercised.
    function automatic t_in_item random_sample();
        int s;
        logic [15:0] x, y;
        logic [19:0] el;
        s = int'($urandom_range(0, MAX_CIRCLES - 1));
        if ($urandom_range(0, 3) != 0 && shd_valid[s]) begin
            x = shd_cx[s] + 16'($signed($urandom_range(0, 2 * shd_rad[s] + 2))
                                - int'(shd_rad[s]) - 1);
            y = shd_cy[s] + 16'($signed($urandom_range(0, 2 * shd_rad[s] + 2))
                                - int'(shd_rad[s]) - 1);
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       el = 20'($urandom);
            1:       el = 20'($urandom_range(0, 2000));
            2:       el = 20'($urandom_range(0, 100000));
            default: el = 20'($urandom_range(0, 20000));
        endcase
        return sample_item(x, y, el, 16'($urandom));
    endfunction

    function automatic t_in_item random_load();
        logic [15:0] r;
        case ($urandom_range(0, 3))
            0:       r = 16'($urandom);
            1:       r = 16'($urandom_range(0, 16));
            default: r = 16'($urandom_range(0, 4000));
        endcase
        return load_item(4'($urandom), $urandom_range(0, 5) != 0, 16'($urandom),
                         16'($urandom), r);
    endfunction

    initial begin
        int ph, n;
        mismatch_count = 0;
        cycle_count    = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        gap_left = 0;
        drv_active = 0;
        shd_cfg  = '0;
        for (int i = 0; i < MAX_CIRCLES; i++) begin
            shd_valid[i] = 0;
            shd_cx[i] = 0;
            shd_cy[i] = 0;
            shd_rad[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sample an empty table, load edges, zero radius, slot priority.
        set_config(1'b1, 24'hFFFFFF, 1'b0, 16'd0, 3'd7);
        queue_item(sample_item(16'd0, 16'd0, 20'hFFFFF, 16'd0));
        queue_item(load_item(4'd0, 1'b1, 16'd100, 16'd100, 16'd0));
        queue_item(sample_item(16'd100, 16'd100, 20'hFFFFF, 16'hFFFF));
        queue_item(sample_item(16'd101, 16'd100, 20'hFFFFF, 16'd0));
        queue_item(load_item(4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_item(sample_item(16'd0, 16'd0, 20'd0, 16'd0));
        queue_item(load_item(4'd3, 1'b1, 16'd0, 16'd0, 16'hFFFF));
        queue_item(sample_item(16'hFFFF, 16'h0, 20'd1, 16'd0));
        queue_item(sample_item(16'd100, 16'd100, 20'd1000, 16'd1));
        queue_item(load_item(4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_item(sample_item(16'd100, 16'd100, 20'd1000, 16'd1));
        drain();
        set_config(1'b1, 24'd0, 1'b1, 16'hFFFF, 3'd0);
        queue_item(sample_item(16'd50, 16'd50, 20'hFFFFF, 16'd0));
        queue_item(sample_item(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'd0));
        drain();
        set_config(1'b0, 24'hFFFFFF, 1'b1, 16'd4096, 3'd2);
        queue_item(sample_item(16'd50, 16'd50, 20'hFFFFF, 16'd0));
        drain();
        write_reg(3'd7, 32'hFFFFFFFF);  // index beyond the register list, ignored

        // Random phases, each under a fresh register setting.
        for (ph = 0; ph < 25; ph++) begin
            set_config($urandom_range(0, 4) != 0,
                       (ph % 5 == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 200000)),
                       1'($urandom_range(0, 1)),
                       (ph % 7 == 0) ? 16'hFFFF : 16'($urandom_range(0, 20000)),
                       3'($urandom));
            // Predictions run at acceptance, so they see the shadow table as it stands then.
            for (n = 0; n < 50; n++) begin
                if ($urandom_range(0, 4) == 0) queue_item(random_load());
                else queue_item(random_sample());
                // Hold off now and then until every result is back.
                if (n == 25 && ph % 4 == 0) drain();
            end
            drain();
        end
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("position_gated_random_stimulus: match");
        end else begin
            $display("position_gated_random_stimulus: mismatch");
        end
        $finish;
    end

endmodule
